// ===== design/dtfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_pkg: shared types and constants of the task-file address former
// field widths, register indexes, reset values and the command records
// passed from the front end through the command queue to the back end
// ----------------------------------------------------------------------------
package dtfa_pkg;

  // field widths
  localparam int unsigned BlockW    = 32;
  localparam int unsigned CountW    = 9;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned HeadsW    = 5;
  localparam int unsigned PerCylW   = 13;  // 31 heads * 255 sectors fits
  localparam int unsigned CylW      = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  // geometry and mode constants
  localparam int unsigned       LbaModeBit    = 6;
  localparam logic [HeadsW-1:0] Head15Min     = 5'd8;
  localparam int unsigned       QUEUE_DEPTH   = 4;

  // register reset values
  localparam logic [ByteW-1:0]  DhPrefixReset = 8'hE0;
  localparam logic [HeadsW-1:0] HeadsReset    = 5'd16;
  localparam logic [ByteW-1:0]  SptReset      = 8'd63;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_DH_PREFIX = 2'd0,
    CFG_HEADS     = 2'd1,
    CFG_SPT       = 2'd2
  } dtfa_cfg_idx_e;

  // task-file fields as formed by the front end
  typedef struct packed {
    logic             count_error;
    logic             chs_mode;        // address fields come from the divider
    logic [ByteW-1:0] sector_byte;
    logic [ByteW-1:0] cylinder_low;
    logic [ByteW-1:0] cylinder_high;
    logic [ByteW-1:0] drive_head_byte;
    logic [ByteW-1:0] count_byte;
    logic             head15_enable;
  } dtfa_fields_t;

  // one classified command waiting for the back end
  typedef struct packed {
    dtfa_fields_t       fields;
    logic [BlockW-1:0]  block;
    logic [PerCylW-1:0] per_cyl;
    logic [ByteW-1:0]   spt;
  } dtfa_cmd_t;

endpackage

// ===== design/dtfa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_front: configuration registers and command classifier
// holds the geometry registers and turns each incoming transaction into a
// command record: zero-count check, lba byte split or chs divisor set-up
// ----------------------------------------------------------------------------
module dtfa_front
  import dtfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic [BlockW-1:0]    block_number_i,
  input  logic [CountW-1:0]    sector_count_i,
  output dtfa_cmd_t            cmd_o
);

  logic [ByteW-1:0]   dh_prefix_q, dh_prefix_d;
  logic [HeadsW-1:0]  heads_q, heads_d;
  logic [ByteW-1:0]   spt_q, spt_d;
  logic [HeadsW-1:0]  heads_eff;
  logic [ByteW-1:0]   spt_eff;
  logic               lba_mode;
  logic               count_zero;

  // register writes
  always_comb begin
    dh_prefix_d = dh_prefix_q;
    heads_d     = heads_q;
    spt_d       = spt_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DH_PREFIX: dh_prefix_d = cfg_data_i;
        CFG_HEADS:     heads_d     = cfg_data_i[HeadsW-1:0];
        CFG_SPT:       spt_d       = cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dh_prefix_q <= DhPrefixReset;
      heads_q     <= HeadsReset;
      spt_q       <= SptReset;
    end else begin
      dh_prefix_q <= dh_prefix_d;
      heads_q     <= heads_d;
      spt_q       <= spt_d;
    end
  end

  // zero geometry is treated as one in the division
  assign heads_eff  = (heads_q == '0) ? HeadsW'(1) : heads_q;
  assign spt_eff    = (spt_q == '0) ? ByteW'(1) : spt_q;
  assign lba_mode   = dh_prefix_q[LbaModeBit];
  assign count_zero = (sector_count_i == '0);

  // classify the command
  always_comb begin
    cmd_o.block   = block_number_i;
    cmd_o.spt     = spt_eff;
    cmd_o.per_cyl = {{(PerCylW-HeadsW){1'b0}}, heads_eff}
                  * {{(PerCylW-ByteW){1'b0}}, spt_eff};
    cmd_o.fields  = '0;
    if (count_zero) begin
      cmd_o.fields.count_error = 1'b1;
    end else begin
      cmd_o.fields.count_byte    = sector_count_i[ByteW-1:0];
      cmd_o.fields.head15_enable = (heads_q >= Head15Min);
      if (lba_mode) begin
        cmd_o.fields.sector_byte     = block_number_i[7:0];
        cmd_o.fields.cylinder_low    = block_number_i[15:8];
        cmd_o.fields.cylinder_high   = block_number_i[23:16];
        cmd_o.fields.drive_head_byte = dh_prefix_q | {4'b0, block_number_i[27:24]};
      end else begin
        cmd_o.fields.chs_mode        = 1'b1;
        cmd_o.fields.drive_head_byte = dh_prefix_q;
      end
    end
  end

endmodule

// ===== design/dtfa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_queue: short command queue between front and back end
// register-based circular buffer, first word shown while not empty
// ----------------------------------------------------------------------------
module dtfa_queue
  import dtfa_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dtfa_cmd_t data_i,
  input  logic      pop_i,
  output dtfa_cmd_t data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dtfa_cmd_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/dtfa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_div: pipelined restoring divider
// one quotient bit per stage, side data travels alongside, the whole
// pipeline holds while the enable is low
// ----------------------------------------------------------------------------
module dtfa_div #(
  parameter int unsigned DividendW = 32,
  parameter int unsigned DivisorW  = 13,
  parameter int unsigned SideW     = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [DividendW-1:0] quotient_o,
  output logic [DivisorW-1:0]  remainder_o,
  output logic [SideW-1:0]     side_o
);

  logic [DividendW-1:0] valid_q;
  logic [DivisorW-1:0]  rem_q  [DividendW];
  logic [DividendW-1:0] acc_q  [DividendW];  // dividend shifts out, quotient in
  logic [DivisorW-1:0]  dvs_q  [DividendW];
  logic [SideW-1:0]     side_q [DividendW];

  for (genvar k = 0; k < DividendW; k++) begin : g_stage
    logic                 src_valid;
    logic [DivisorW-1:0]  src_rem;
    logic [DividendW-1:0] src_acc;
    logic [DivisorW-1:0]  src_dvs;
    logic [SideW-1:0]     src_side;
    logic [DivisorW:0]    trial;
    logic [DivisorW:0]    diff;
    logic                 take;
    logic [DivisorW-1:0]  rem_d;
    logic [DividendW-1:0] acc_d;

    // stage source
    if (k == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_rem   = '0;
      assign src_acc   = dividend_i;
      assign src_dvs   = divisor_i;
      assign src_side  = side_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_rem   = rem_q[k-1];
      assign src_acc   = acc_q[k-1];
      assign src_dvs   = dvs_q[k-1];
      assign src_side  = side_q[k-1];
    end

    // one restoring step
    assign trial = {src_rem, src_acc[DividendW-1]};
    assign take  = (trial >= {1'b0, src_dvs});
    assign diff  = trial - {1'b0, src_dvs};
    assign rem_d = take ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    assign acc_d = {src_acc[DividendW-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        acc_q[k]  <= acc_d;
        dvs_q[k]  <= src_dvs;
        side_q[k] <= src_side;
      end
    end
  end

  assign valid_o     = valid_q[DividendW-1];
  assign quotient_o  = acc_q[DividendW-1];
  assign remainder_o = rem_q[DividendW-1];
  assign side_o      = side_q[DividendW-1];

endmodule

// ===== design/dtfa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_back: chs conversion pipeline and result register
// cylinder = block / (heads * spt), then head and sector from the
// remainder divided by spt; lba and error commands pass through unchanged
// ----------------------------------------------------------------------------
module dtfa_back
  import dtfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dtfa_cmd_t    cmd_i,
  input  logic         pop_i,
  output logic         empty_o,
  output dtfa_fields_t result_o
);

  typedef struct packed {
    dtfa_fields_t     fields;
    logic [ByteW-1:0] spt;
  } dtfa_side1_t;

  typedef struct packed {
    dtfa_fields_t    fields;
    logic [CylW-1:0] cylinder;
  } dtfa_side2_t;

  localparam int unsigned Side1W = $bits(dtfa_side1_t);
  localparam int unsigned Side2W = $bits(dtfa_side2_t);

  logic               en;
  dtfa_side1_t        side1_in, side1_out;
  dtfa_side2_t        side2_in, side2_out;
  logic               div1_valid, div2_valid;
  logic [BlockW-1:0]  cyl_quo;
  logic [PerCylW-1:0] cyl_rem;
  logic [PerCylW-1:0] head_quo;
  logic [ByteW-1:0]   sec_rem;
  dtfa_fields_t       result_d, result_q;
  logic               out_valid_q, out_valid_d;

  // the pipeline moves whenever the result register is free or being taken
  assign en         = !out_valid_q || pop_i;
  assign in_ready_o = en;

  // cylinder division
  assign side1_in.fields = cmd_i.fields;
  assign side1_in.spt    = cmd_i.spt;

  dtfa_div #(
    .DividendW (BlockW),
    .DivisorW  (PerCylW),
    .SideW     (Side1W)
  ) u_div_cyl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .dividend_i  (cmd_i.block),
    .divisor_i   (cmd_i.per_cyl),
    .side_i      (side1_in),
    .valid_o     (div1_valid),
    .quotient_o  (cyl_quo),
    .remainder_o (cyl_rem),
    .side_o      (side1_out)
  );

  // head and sector division
  assign side2_in.fields   = side1_out.fields;
  assign side2_in.cylinder = cyl_quo[CylW-1:0];

  dtfa_div #(
    .DividendW (PerCylW),
    .DivisorW  (ByteW),
    .SideW     (Side2W)
  ) u_div_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (div1_valid),
    .dividend_i  (cyl_rem),
    .divisor_i   (side1_out.spt),
    .side_i      (side2_in),
    .valid_o     (div2_valid),
    .quotient_o  (head_quo),
    .remainder_o (sec_rem),
    .side_o      (side2_out)
  );

  // final field selection
  always_comb begin
    result_d = side2_out.fields;
    if (side2_out.fields.chs_mode) begin
      result_d.sector_byte     = sec_rem + 1'b1;
      result_d.cylinder_low    = side2_out.cylinder[7:0];
      result_d.cylinder_high   = side2_out.cylinder[15:8];
      result_d.drive_head_byte = side2_out.fields.drive_head_byte | head_quo[ByteW-1:0];
    end
  end

  // result register
  assign out_valid_d = en ? div2_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = result_q;

endmodule

// ===== design/disk_task_file_address_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_task_file_address_top: disk task-file address former
// turns a logical block number and sector count into the task-file bytes,
// by byte split in lba mode or by chs conversion through a divider pipeline
//
//   channel   direction  handshake           transaction moves
//   command   in         push / full         block_number, sector_count
//   result    out        empty / pop         count_error .. head15_enable
//   config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one command per cycle sustained while results are popped; a command taken is
// written to the command queue at the accept, then passes 32 stages of cylinder
// division, 13 stages of head/sector division and the result register.
// no clearing pass after reset; registers take their reset values at once.
// a result not popped holds the back-end pipeline; the queue keeps taking
// commands until it is full. config writes are always ready.
// ----------------------------------------------------------------------------
module disk_task_file_address_top
  import dtfa_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 push,
  output logic                 full,
  input  logic [BlockW-1:0]    block_number_i,
  input  logic [CountW-1:0]    sector_count_i,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output logic                 count_error_o,
  output logic [ByteW-1:0]     sector_byte_o,
  output logic [ByteW-1:0]     cylinder_low_o,
  output logic [ByteW-1:0]     cylinder_high_o,
  output logic [ByteW-1:0]     drive_head_byte_o,
  output logic [ByteW-1:0]     count_byte_o,
  output logic                 head15_enable_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  dtfa_cmd_t    front_cmd;
  dtfa_cmd_t    queue_cmd;
  logic         queue_empty;
  logic         queue_full;
  logic         queue_push;
  logic         queue_pop;
  logic         back_ready;
  dtfa_fields_t result;

  assign cfg_ready_o = 1'b1;
  assign full        = queue_full;
  assign queue_push  = push && !queue_full;
  assign queue_pop   = back_ready && !queue_empty;

  // front end: registers and classification
  dtfa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .block_number_i (block_number_i),
    .sector_count_i (sector_count_i),
    .cmd_o          (front_cmd)
  );

  // command queue
  dtfa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .data_i  (front_cmd),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  // back end: conversion and result register
  dtfa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!queue_empty),
    .in_ready_o (back_ready),
    .cmd_i      (queue_cmd),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result)
  );

  assign count_error_o     = result.count_error;
  assign sector_byte_o     = result.sector_byte;
  assign cylinder_low_o    = result.cylinder_low;
  assign cylinder_high_o   = result.cylinder_high;
  assign drive_head_byte_o = result.drive_head_byte;
  assign count_byte_o      = result.count_byte;
  assign head15_enable_o   = result.head15_enable;

endmodule

// ===== test/dtfa_task_file_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfa_task_file_checker: result checker for the task-file address former
// follows the register writes and the command channel, forms the expected
// task-file bytes of every accepted command and compares each popped result,
// field by field, with the oldest expectation
// ----------------------------------------------------------------------------
module dtfa_task_file_checker
  import dtfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 push,
  input  logic                 full,
  input  logic [BlockW-1:0]    block_number_i,
  input  logic [CountW-1:0]    sector_count_i,
  // result channel
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 count_error_i,
  input  logic [ByteW-1:0]     sector_byte_i,
  input  logic [ByteW-1:0]     cylinder_low_i,
  input  logic [ByteW-1:0]     cylinder_high_i,
  input  logic [ByteW-1:0]     drive_head_byte_i,
  input  logic [ByteW-1:0]     count_byte_i,
  input  logic                 head15_enable_i,
  // configuration channel
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // status towards the stimulus
  output int                   mismatch_count_o,
  output int                   pending_count_o
);

  typedef struct packed {
    logic             count_error;
    logic [ByteW-1:0] sector_byte;
    logic [ByteW-1:0] cylinder_low;
    logic [ByteW-1:0] cylinder_high;
    logic [ByteW-1:0] drive_head_byte;
    logic [ByteW-1:0] count_byte;
    logic             head15_enable;
  } task_file_t;

  localparam logic [CountW-1:0] FullCount = 9'd256;

  // shadow copy of the geometry registers
  logic [ByteW-1:0]  dh_prefix;
  logic [HeadsW-1:0] heads_reg;
  logic [ByteW-1:0]  spt_reg;

  task_file_t task_file_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] task-file checker: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  // task-file bytes for one command under the current geometry
  function automatic task_file_t form_task_file(input logic [BlockW-1:0] blk,
                                                input logic [CountW-1:0] cnt);
    task_file_t  tf;
    logic [31:0] heads;
    logic [31:0] spt;
    logic [31:0] per_cyl;
    logic [31:0] cylinder;
    logic [31:0] head;
    logic [31:0] sector;
    tf = '0;
    if (cnt == '0) begin
      tf.count_error = 1'b1;
      return tf;
    end
    if (dh_prefix[LbaModeBit]) begin
      tf.sector_byte     = blk[7:0];
      tf.cylinder_low    = blk[15:8];
      tf.cylinder_high   = blk[23:16];
      tf.drive_head_byte = dh_prefix | {4'h0, blk[27:24]};
    end else begin
      // zero geometry divides as one
      heads    = (heads_reg == '0) ? 32'd1 : 32'(heads_reg);
      spt      = (spt_reg == '0) ? 32'd1 : 32'(spt_reg);
      per_cyl  = heads * spt;
      cylinder = blk / per_cyl;
      head     = (blk % per_cyl) / spt;
      sector   = blk % spt;
      tf.sector_byte     = 8'(sector + 32'd1);
      tf.cylinder_low    = cylinder[7:0];
      tf.cylinder_high   = cylinder[15:8];
      tf.drive_head_byte = dh_prefix | head[7:0];
    end
    tf.count_byte    = (cnt == FullCount) ? 8'h00 : cnt[7:0];
    tf.head15_enable = (heads_reg >= Head15Min);
    return tf;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    task_file_t want;
    if (!rst_ni) begin
      dh_prefix        = DhPrefixReset;
      heads_reg        = HeadsReset;
      spt_reg          = SptReset;
      task_file_q      = {};
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // result transaction
      if (pop && !empty) begin
        if (task_file_q.size() == 0) begin
          report_mismatch("result popped with nothing outstanding");
        end else begin
          want = task_file_q.pop_front();
          compare_field("count_error", 8'(count_error_i), 8'(want.count_error));
          compare_field("sector_byte", sector_byte_i, want.sector_byte);
          compare_field("cylinder_low", cylinder_low_i, want.cylinder_low);
          compare_field("cylinder_high", cylinder_high_i, want.cylinder_high);
          compare_field("drive_head_byte", drive_head_byte_i, want.drive_head_byte);
          compare_field("count_byte", count_byte_i, want.count_byte);
          compare_field("head15_enable", 8'(head15_enable_i),
                        8'(want.head15_enable));
        end
      end
      // command transaction
      if (push && !full)
        task_file_q.push_back(form_task_file(block_number_i, sector_count_i));
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (dtfa_cfg_idx_e'(cfg_index_i))
          CFG_DH_PREFIX: dh_prefix = cfg_data_i;
          CFG_HEADS:     heads_reg = cfg_data_i[HeadsW-1:0];
          CFG_SPT:       spt_reg   = cfg_data_i;
          default: ;
        endcase
      end
      pending_count_o = task_file_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the task-file address former testbench
// writes the geometry registers between phases, sends directed commands
// around the lba/chs corners and then random commands with random gaps and
// result stalls; the checker beside the block scores every result
// ----------------------------------------------------------------------------
module testbench;
  import dtfa_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned          RandPhases   = 11;
  localparam int unsigned          PhaseItems   = 94;
  localparam int unsigned          SettleCycles = 60;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 push           = 1'b0;
  logic                 full;
  logic [BlockW-1:0]    block_number_i = '0;
  logic [CountW-1:0]    sector_count_i = '0;
  logic                 empty;
  logic                 pop            = 1'b0;
  logic                 count_error_o;
  logic [ByteW-1:0]     sector_byte_o;
  logic [ByteW-1:0]     cylinder_low_o;
  logic [ByteW-1:0]     cylinder_high_o;
  logic [ByteW-1:0]     drive_head_byte_o;
  logic [ByteW-1:0]     count_byte_o;
  logic                 head15_enable_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;

  int mismatch_count;
  int pending_count;
  bit idling_on = 1'b1;

  disk_task_file_address_top u_dut (
    .clk_i, .rst_ni,
    .push, .full, .block_number_i, .sector_count_i,
    .empty, .pop, .count_error_o, .sector_byte_o, .cylinder_low_o,
    .cylinder_high_o, .drive_head_byte_o, .count_byte_o, .head15_enable_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  dtfa_task_file_checker u_checker (
    .clk_i, .rst_ni,
    .push, .full, .block_number_i, .sector_count_i,
    .empty, .pop,
    .count_error_i     (count_error_o),
    .sector_byte_i     (sector_byte_o),
    .cylinder_low_i    (cylinder_low_o),
    .cylinder_high_i   (cylinder_high_o),
    .drive_head_byte_i (drive_head_byte_o),
    .count_byte_i      (count_byte_o),
    .head15_enable_i   (head15_enable_o),
    .cfg_valid_i,
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // overall time limit
  initial begin
    #1ms;
    $display("[disk_task_file_address_top] ERROR");
    $finish;
  end

  // result side: pop with random stall bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 5) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one command transaction, optionally after an idle burst
  task automatic send_cmd(input logic [BlockW-1:0] blk, input logic [CountW-1:0] cnt);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push           <= 1'b1;
    block_number_i <= blk;
    sector_count_i <= cnt;
    do @(posedge clk_i); while (full);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain;
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [7:0] prefix, input logic [7:0] heads,
                              input logic [7:0] spt);
    drain();
    write_reg(CFG_DH_PREFIX, prefix);
    write_reg(CFG_HEADS, heads);
    write_reg(CFG_SPT, spt);
  endtask

  function automatic logic [BlockW-1:0] rand_block();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom() & 32'h00FF_FFFF;
      2:       return $urandom_range(0, 20000);
      default: return $urandom_range(0, 2000000);
    endcase
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 9'd256;
      2:       return CountW'($urandom_range(257, 511));
      default: return CountW'($urandom_range(1, 255));
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    logic [7:0] prefix;
    logic [7:0] heads;
    logic [7:0] spt;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: lba mode, byte split and count corners
    send_cmd(32'h0000_0000, 9'd1);
    send_cmd(32'hFFFF_FFFF, 9'd256);
    send_cmd(32'h0F00_0000, 9'd0);
    send_cmd(32'h1234_5678, 9'd255);
    send_cmd(32'hA5A5_A5A5, 9'd257);
    send_cmd(32'h5A5A_5A5A, 9'd511);

    // chs mode at the usual 16 x 63 geometry
    set_geometry(8'hA0, 8'd16, 8'd63);
    send_cmd(32'd0, 9'd1);
    send_cmd(32'd1007, 9'd8);
    send_cmd(32'd1008, 9'd0);
    send_cmd(32'hFFFF_FFFF, 9'd256);

    // zero geometry divides as one, head15 from the raw register
    set_geometry(8'h00, 8'd0, 8'd0);
    send_cmd(32'd0, 9'd3);
    send_cmd(32'd65535, 9'd200);
    send_cmd(32'd65536, 9'd300);

    // heads above sixteen, upper data bits dropped by the register
    set_geometry(8'hA0, 8'hFF, 8'd255);
    send_cmd(32'd7904, 9'd1);
    send_cmd(32'd7905, 9'd64);
    send_cmd(32'hFFFF_FFFF, 9'd128);

    // one sector per cylinder: cylinder overflow
    set_geometry(8'h10, 8'd1, 8'd1);
    write_reg(CfgIdxUnused, 8'h5A);
    send_cmd(32'hFFFF_FFFF, 9'd2);
    send_cmd(32'h0001_0000, 9'd256);

    // all prefix bits set, head15 boundary either side
    set_geometry(8'hFF, 8'd8, 8'd17);
    send_cmd(32'hFFFF_FFFF, 9'd9);
    send_cmd(32'h0000_0100, 9'd10);
    set_geometry(8'h00, 8'd7, 8'd17);
    send_cmd(32'd118, 9'd11);
    send_cmd(32'd119, 9'd12);

    // random phases under random geometry, without idling in phases 2, 6 and 10 (the last)
    for (int phase = 0; phase < RandPhases; phase++) begin
      prefix    = 8'($urandom());
      prefix[6] = phase[0];
      case ($urandom_range(0, 7))
        0:       heads = 8'd0;
        1:       heads = 8'($urandom());
        default: heads = 8'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 7))
        0:       spt = 8'd0;
        1:       spt = 8'd255;
        2:       spt = 8'd1;
        default: spt = 8'($urandom_range(1, 255));
      endcase
      set_geometry(prefix, heads, spt);
      idling_on = (phase < RandPhases - 1) && (phase % 4 != 2);
      for (int n = 0; n < PhaseItems; n++)
        send_cmd(rand_block(), rand_count());
    end

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[disk_task_file_address_top] OK");
    end else begin
      $display("[disk_task_file_address_top] ERROR");
    end
    $finish;
  end

endmodule
